### rtl/core/preemptive_priority_scheduler_top_macros.svh
// ---------------------------------------------------------------------------
// preemptive priority scheduler assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define PPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the preemptive priority scheduler
// ---------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MaxProcsDefault = 16;
  localparam int unsigned TimeW           = 16;
  localparam int unsigned IdW             = 8;
  localparam int unsigned PrioW           = 8;
  localparam logic [TimeW-1:0] TimeMax    = '1;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  // one entry of the process table
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] remaining;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] response;
    logic             responded;
    logic             done;
  } slot_t;

endpackage

### rtl/core/pps_slot_mem.sv
// ---------------------------------------------------------------------------
// pps_slot_mem
// process table: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module pps_slot_mem #(
  parameter int unsigned MaxProcs = pps_pkg::MaxProcsDefault,
  parameter int unsigned IdxW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  pps_pkg::slot_t      wr_data_i,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  output pps_pkg::slot_t      rd_data_o
);

  pps_pkg::slot_t mem [MaxProcs];
  pps_pkg::slot_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/core/preemptive_priority_scheduler_top.sv
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// preemptive priority scheduler over a table of up to MAX_PROCS processes
// ---------------------------------------------------------------------------
// Load items append a process (id, arrival, burst, priority) to the table;
// loads with a zero id or zero burst, or into a full table, are dropped.
// Clear items empty the table and set time to zero. Kind 3 is ignored.
// Each tick item yields one result item: the process run in that time unit
// (0 when idle) and, when it completes, its turnaround, waiting and response
// times. No new item is taken until a tick is through: the table sits in a
// single-read-port memory, so the incumbent (when one is held) and then
// every loaded slot are read one per cycle through one shared compare unit,
// and a final write-back state, once the previous result has been taken,
// writes back the chosen slot and fills the output register. Time saturates
// at its maximum.
// ---------------------------------------------------------------------------
`include "preemptive_priority_scheduler_top_macros.svh"

module preemptive_priority_scheduler_top #(
  parameter int unsigned MAX_PROCS = pps_pkg::MaxProcsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 in_kind_i,
  input  logic [pps_pkg::IdW-1:0]    in_proc_id_i,
  input  logic [pps_pkg::TimeW-1:0]  in_arrival_i,
  input  logic [pps_pkg::TimeW-1:0]  in_burst_i,
  input  logic [pps_pkg::PrioW-1:0]  in_prio_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pps_pkg::TimeW-1:0]  out_tick_time_o,
  output logic [pps_pkg::IdW-1:0]    out_running_id_o,
  output logic                       out_finish_valid_o,
  output logic [pps_pkg::IdW-1:0]    out_finish_id_o,
  output logic [pps_pkg::TimeW-1:0]  out_turnaround_o,
  output logic [pps_pkg::TimeW-1:0]  out_waiting_o,
  output logic [pps_pkg::TimeW-1:0]  out_response_o,
  output logic                       out_all_done_o
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PROCS);
  localparam int unsigned TW = pps_pkg::TimeW;

  // sequencer and scan state
  pps_pkg::state_e state_q, state_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            eval_v_q, eval_v_d;
  logic [IdxW-1:0] eval_idx_q, eval_idx_d;

  // best candidate so far, entry copy kept for the write-back
  logic            best_v_q, best_v_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  pps_pkg::slot_t  best_q, best_d;

  // scheduler state
  logic [CntW-1:0] loaded_q, loaded_d;
  logic [CntW-1:0] done_q, done_d;
  logic [TW-1:0]   now_q, now_d;
  logic [IdxW-1:0] cur_slot_q, cur_slot_d;
  logic            cur_v_q, cur_v_d;

  // output register
  logic                     out_v_q, out_v_d;
  logic [TW-1:0]            o_time_q, o_time_d;
  logic [pps_pkg::IdW-1:0]  o_run_q, o_run_d;
  logic                     o_fin_q, o_fin_d;
  logic [pps_pkg::IdW-1:0]  o_fid_q, o_fid_d;
  logic [TW-1:0]            o_tat_q, o_tat_d;
  logic [TW-1:0]            o_wait_q, o_wait_d;
  logic [TW-1:0]            o_resp_q, o_resp_d;
  logic                     o_all_q, o_all_d;

  // memory port
  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  pps_pkg::slot_t  wr_data, rd_data;

  logic            in_acc;
  pps_pkg::kind_e  kind;
  logic            cand_better;
  logic            upd_go;
  pps_pkg::slot_t  upd_slot;
  logic [TW-1:0]   now_nx;
  logic [TW-1:0]   ta;
  logic [CntW-1:0] done_nx;

  pps_slot_mem #(
    .MaxProcs (MAX_PROCS),
    .IdxW     (IdxW)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != pps_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign kind       = pps_pkg::kind_e'(in_kind_i);

  // shared compare unit: the slot read last cycle against the best so far;
  // strict compares keep the incumbent and then the lower slot on a tie
  assign cand_better = eval_v_q && !rd_data.done && (rd_data.arrival <= now_q) &&
                       (!best_v_q || (rd_data.prio < best_q.prio) ||
                        ((rd_data.prio == best_q.prio) &&
                         (rd_data.arrival < best_q.arrival)));

  // write-back may go once the previous result has been taken
  assign upd_go = (state_q == pps_pkg::ST_UPD) && (!out_v_q || !out_stall_i);

  // time saturates at its maximum
  assign now_nx = (now_q == pps_pkg::TimeMax) ? pps_pkg::TimeMax : now_q + TW'(1);
  assign ta     = now_nx - best_q.arrival;

  always_comb begin
    upd_slot = best_q;
    if (!best_q.responded) begin
      upd_slot.response  = now_q - best_q.arrival;
      upd_slot.responded = 1'b1;
    end
    if (best_q.remaining != '0) begin
      upd_slot.remaining = best_q.remaining - TW'(1);
    end
    upd_slot.done = (upd_slot.remaining == '0);
  end

  assign done_nx = (best_v_q && upd_slot.done) ? done_q + CntW'(1) : done_q;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    eval_v_d   = 1'b0;
    eval_idx_d = eval_idx_q;
    best_v_d   = best_v_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    loaded_d   = loaded_q;
    done_d     = done_q;
    now_d      = now_q;
    cur_slot_d = cur_slot_q;
    cur_v_d    = cur_v_q;
    out_v_d    = out_v_q && out_stall_i;
    o_time_d   = o_time_q;
    o_run_d    = o_run_q;
    o_fin_d    = o_fin_q;
    o_fid_d    = o_fid_q;
    o_tat_d    = o_tat_q;
    o_wait_d   = o_wait_q;
    o_resp_d   = o_resp_q;
    o_all_d    = o_all_q;
    wr_en      = 1'b0;
    wr_addr    = loaded_q[IdxW-1:0];
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = cur_slot_q;

    if (cand_better) begin
      best_v_d   = 1'b1;
      best_idx_d = eval_idx_q;
      best_d     = rd_data;
    end

    case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            pps_pkg::KIND_LOAD: begin
              if ((loaded_q < CntMax) && (in_burst_i != '0) && (in_proc_id_i != '0)) begin
                wr_en             = 1'b1;
                wr_data.id        = in_proc_id_i;
                wr_data.arrival   = in_arrival_i;
                wr_data.burst     = in_burst_i;
                wr_data.remaining = in_burst_i;
                wr_data.prio      = in_prio_i;
                loaded_d          = loaded_q + CntW'(1);
              end
            end
            pps_pkg::KIND_TICK: begin
              // incumbent goes through the compare unit first
              rd_en      = cur_v_q;
              eval_v_d   = cur_v_q;
              eval_idx_d = cur_slot_q;
              scan_d     = '0;
              best_v_d   = 1'b0;
              state_d    = pps_pkg::ST_SCAN;
            end
            pps_pkg::KIND_CLEAR: begin
              loaded_d = '0;
              done_d   = '0;
              now_d    = '0;
              cur_v_d  = 1'b0;
              cur_slot_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      pps_pkg::ST_SCAN: begin
        if (scan_q < loaded_q) begin
          rd_en      = 1'b1;
          rd_addr    = scan_q[IdxW-1:0];
          eval_v_d   = 1'b1;
          eval_idx_d = scan_q[IdxW-1:0];
          scan_d     = scan_q + CntW'(1);
        end else begin
          // last slot is judged this cycle
          state_d = pps_pkg::ST_UPD;
        end
      end

      pps_pkg::ST_UPD: begin
        if (upd_go) begin
          now_d    = now_nx;
          out_v_d  = 1'b1;
          o_time_d = now_q;
          o_run_d  = '0;
          o_fin_d  = 1'b0;
          o_fid_d  = '0;
          o_tat_d  = '0;
          o_wait_d = '0;
          o_resp_d = '0;
          cur_v_d  = 1'b0;
          if (best_v_q) begin
            wr_en      = 1'b1;
            wr_addr    = best_idx_q;
            wr_data    = upd_slot;
            o_run_d    = best_q.id;
            cur_slot_d = best_idx_q;
            cur_v_d    = !upd_slot.done;
            if (upd_slot.done) begin
              o_fin_d  = 1'b1;
              o_fid_d  = best_q.id;
              o_tat_d  = ta;
              o_wait_d = (ta >= best_q.burst) ? ta - best_q.burst : '0;
              o_resp_d = upd_slot.response;
            end
          end
          done_d  = done_nx;
          o_all_d = (done_nx == loaded_q);
          state_d = pps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pps_pkg::ST_IDLE;
      scan_q     <= '0;
      eval_v_q   <= 1'b0;
      best_v_q   <= 1'b0;
      loaded_q   <= '0;
      done_q     <= '0;
      now_q      <= '0;
      cur_slot_q <= '0;
      cur_v_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      eval_v_q   <= eval_v_d;
      best_v_q   <= best_v_d;
      loaded_q   <= loaded_d;
      done_q     <= done_d;
      now_q      <= now_d;
      cur_slot_q <= cur_slot_d;
      cur_v_q    <= cur_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    eval_idx_q <= eval_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    o_time_q   <= o_time_d;
    o_run_q    <= o_run_d;
    o_fin_q    <= o_fin_d;
    o_fid_q    <= o_fid_d;
    o_tat_q    <= o_tat_d;
    o_wait_q   <= o_wait_d;
    o_resp_q   <= o_resp_d;
    o_all_q    <= o_all_d;
  end

  assign out_valid_o        = out_v_q;
  assign out_tick_time_o    = o_time_q;
  assign out_running_id_o   = o_run_q;
  assign out_finish_valid_o = o_fin_q;
  assign out_finish_id_o    = o_fid_q;
  assign out_turnaround_o   = o_tat_q;
  assign out_waiting_o      = o_wait_q;
  assign out_response_o     = o_resp_q;
  assign out_all_done_o     = o_all_q;

  // completions never outnumber loaded processes
  `PPS_ASSERT_NEVER(a_done_le_loaded, clk_i, rst_ni, done_q > loaded_q, "done count above loaded count")
  // an incumbent always lies inside the loaded part of the table
  `PPS_ASSERT(a_cur_in_table, clk_i, rst_ni, cur_v_q |-> ({{(CntW-IdxW){1'b0}}, cur_slot_q} < loaded_q), "incumbent outside table")
  // a completing process is the one that ran
  `PPS_ASSERT(a_fin_is_run, clk_i, rst_ni, (out_v_q && o_fin_q) |-> (o_fid_q == o_run_q), "finish id differs from running id")

endmodule

### test/preemptive_priority_scheduler_checker.sv
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler_checker
// watches both channels of the scheduler, keeps its own copy of the process
// table and time, predicts every tick result and compares it field by field
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler_checker #(
  parameter int unsigned MAX_PROCS = pps_pkg::MaxProcsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [1:0]                       in_kind_i,
  input  logic [pps_pkg::IdW-1:0]          in_proc_id_i,
  input  logic [pps_pkg::TimeW-1:0]        in_arrival_i,
  input  logic [pps_pkg::TimeW-1:0]        in_burst_i,
  input  logic [pps_pkg::PrioW-1:0]        in_prio_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [pps_pkg::TimeW-1:0]        out_tick_time_i,
  input  logic [pps_pkg::IdW-1:0]          out_running_id_i,
  input  logic                             out_finish_valid_i,
  input  logic [pps_pkg::IdW-1:0]          out_finish_id_i,
  input  logic [pps_pkg::TimeW-1:0]        out_turnaround_i,
  input  logic [pps_pkg::TimeW-1:0]        out_waiting_i,
  input  logic [pps_pkg::TimeW-1:0]        out_response_i,
  input  logic                             out_all_done_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  // widest result field, used for reporting
  typedef logic [pps_pkg::TimeW-1:0] field_t;

  typedef struct packed {
    logic [pps_pkg::TimeW-1:0] tick_time;
    logic [pps_pkg::IdW-1:0]   running_id;
    logic                      finish_valid;
    logic [pps_pkg::IdW-1:0]   finish_id;
    logic [pps_pkg::TimeW-1:0] turnaround;
    logic [pps_pkg::TimeW-1:0] waiting;
    logic [pps_pkg::TimeW-1:0] response;
    logic                      all_done;
  } tick_report_t;

  // shadow of the process table and scheduler state
  pps_pkg::slot_t            proc_tab [MAX_PROCS];
  int                        loaded_n;
  int                        finished_n;
  logic [pps_pkg::TimeW-1:0] sched_now;
  int                        cur_slot;
  bit                        cur_ok;

  tick_report_t     pending_reports [$];
  int unsigned      fails;

  function automatic void clear_schedule();
    loaded_n   = 0;
    finished_n = 0;
    sched_now  = '0;
    cur_slot   = 0;
    cur_ok     = 1'b0;
  endfunction

  function automatic bit eligible_at(int s, logic [pps_pkg::TimeW-1:0] t);
    return s < loaded_n && !proc_tab[s].done && proc_tab[s].arrival <= t;
  endfunction

  function automatic void add_process(logic [pps_pkg::IdW-1:0] id,
                                      logic [pps_pkg::TimeW-1:0] arr,
                                      logic [pps_pkg::TimeW-1:0] bur,
                                      logic [pps_pkg::PrioW-1:0] pr);
    pps_pkg::slot_t s;
    // full table, zero id and zero burst are dropped
    if (loaded_n < int'(MAX_PROCS) && bur != '0 && id != '0) begin
      s           = '0;
      s.id        = id;
      s.arrival   = arr;
      s.burst     = bur;
      s.remaining = bur;
      s.prio      = pr;
      proc_tab[loaded_n] = s;
      loaded_n++;
    end
  endfunction

  // one time unit: pick the best ready process, run it, report
  function automatic tick_report_t advance_schedule();
    tick_report_t              r;
    logic [pps_pkg::TimeW-1:0] t;
    logic [pps_pkg::TimeW-1:0] ta;
    int                        pick;
    r    = '0;
    t    = sched_now;
    pick = -1;
    if (cur_ok && eligible_at(cur_slot, t)) pick = cur_slot;
    for (int j = 0; j < loaded_n; j++) begin
      if (eligible_at(j, t)) begin
        if (pick < 0 || proc_tab[j].prio < proc_tab[pick].prio ||
            (proc_tab[j].prio == proc_tab[pick].prio &&
             proc_tab[j].arrival < proc_tab[pick].arrival))
          pick = j;
      end
    end
    sched_now = (t != pps_pkg::TimeMax) ? t + 1'b1 : t;
    if (pick >= 0) begin
      r.running_id = proc_tab[pick].id;
      if (!proc_tab[pick].responded) begin
        proc_tab[pick].response  = t - proc_tab[pick].arrival;
        proc_tab[pick].responded = 1'b1;
      end
      if (proc_tab[pick].remaining != '0)
        proc_tab[pick].remaining = proc_tab[pick].remaining - 1'b1;
      cur_slot = pick;
      cur_ok   = 1'b1;
      if (proc_tab[pick].remaining == '0) begin
        ta = sched_now - proc_tab[pick].arrival;
        proc_tab[pick].done = 1'b1;
        finished_n++;
        cur_ok         = 1'b0;
        r.finish_valid = 1'b1;
        r.finish_id    = proc_tab[pick].id;
        r.turnaround   = ta;
        // negative waiting only after time saturated
        r.waiting      = (ta >= proc_tab[pick].burst) ? ta - proc_tab[pick].burst : '0;
        r.response     = proc_tab[pick].response;
      end
    end else begin
      cur_ok = 1'b0;
    end
    r.tick_time = t;
    r.all_done  = (finished_n == loaded_n);
    return r;
  endfunction

  function automatic void check_field(string name, field_t want, field_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_report_t seen;
    tick_report_t want;
    if (!rst_ni) begin
      clear_schedule();
      pending_reports.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{out_tick_time_i, out_running_id_i, out_finish_valid_i, out_finish_id_i,
                 out_turnaround_i, out_waiting_i, out_response_i, out_all_done_i};
        if (pending_reports.size() == 0) begin
          $error("result at tick_time %0d with nothing expected", seen.tick_time);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          check_field("tick_time", want.tick_time, seen.tick_time);
          check_field("running_id", field_t'(want.running_id),
                      field_t'(seen.running_id));
          check_field("finish_valid", field_t'(want.finish_valid),
                      field_t'(seen.finish_valid));
          check_field("finish_id", field_t'(want.finish_id), field_t'(seen.finish_id));
          check_field("turnaround", want.turnaround, seen.turnaround);
          check_field("waiting", want.waiting, seen.waiting);
          check_field("response", want.response, seen.response);
          check_field("all_done", field_t'(want.all_done), field_t'(seen.all_done));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (pps_pkg::kind_e'(in_kind_i))
          pps_pkg::KIND_LOAD:
            add_process(in_proc_id_i, in_arrival_i, in_burst_i, in_prio_i);
          pps_pkg::KIND_TICK:  pending_reports.push_back(advance_schedule());
          pps_pkg::KIND_CLEAR: clear_schedule();
          default:    ;
        endcase
      end
      pending_o    <= pending_reports.size();
      fail_count_o <= fails;
    end
  end

endmodule

### test/tb_preemptive_priority_scheduler_top.sv
// ---------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_top
// drives load, tick, clear and unused items into the scheduler: a directed
// set, then random well-formed schedules with noise, under several idling
// and stalling mixes; the checker predicts and compares every tick result
// and this module gives the verdict
// ---------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_top;

  localparam int unsigned RandomItems   = 750;
  localparam int unsigned LongHold      = 300;   // receiver hold-off in cycles
  localparam int unsigned WatchdogLimit = 4000;  // quiet cycles before giving up
  localparam int unsigned DrainCycles   = 40;    // idle cycles after the final drain

  typedef logic [pps_pkg::IdW-1:0]   id_t;
  typedef logic [pps_pkg::TimeW-1:0] tval_t;
  typedef logic [pps_pkg::PrioW-1:0] prio_t;

  logic                       clk_i              = 1'b0;
  logic                       rst_ni             = 1'b0;
  logic                       in_valid_i         = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 in_kind_i          = pps_pkg::KIND_NONE;
  logic [pps_pkg::IdW-1:0]    in_proc_id_i       = '0;
  logic [pps_pkg::TimeW-1:0]  in_arrival_i       = '0;
  logic [pps_pkg::TimeW-1:0]  in_burst_i         = '0;
  logic [pps_pkg::PrioW-1:0]  in_prio_i          = '0;
  logic                       out_valid_o;
  logic                       out_stall_i        = 1'b0;
  logic [pps_pkg::TimeW-1:0]  out_tick_time_o;
  logic [pps_pkg::IdW-1:0]    out_running_id_o;
  logic                       out_finish_valid_o;
  logic [pps_pkg::IdW-1:0]    out_finish_id_o;
  logic [pps_pkg::TimeW-1:0]  out_turnaround_o;
  logic [pps_pkg::TimeW-1:0]  out_waiting_o;
  logic [pps_pkg::TimeW-1:0]  out_response_o;
  logic                       out_all_done_o;

  int unsigned fail_count;
  int unsigned pending;

  // idling mix: sender gap and receiver stall chances in percent
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  // long receiver hold-off, requested here and counted out by the receiver
  int unsigned hold_asked   = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  int unsigned items_sent   = 0;
  int unsigned ticks_sent   = 0;
  int unsigned scenarios    = 0;

  preemptive_priority_scheduler_top #(
    .MAX_PROCS (pps_pkg::MaxProcsDefault)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_kind_i          (in_kind_i),
    .in_proc_id_i       (in_proc_id_i),
    .in_arrival_i       (in_arrival_i),
    .in_burst_i         (in_burst_i),
    .in_prio_i          (in_prio_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_tick_time_o    (out_tick_time_o),
    .out_running_id_o   (out_running_id_o),
    .out_finish_valid_o (out_finish_valid_o),
    .out_finish_id_o    (out_finish_id_o),
    .out_turnaround_o   (out_turnaround_o),
    .out_waiting_o      (out_waiting_o),
    .out_response_o     (out_response_o),
    .out_all_done_o     (out_all_done_o)
  );

  preemptive_priority_scheduler_checker #(
    .MAX_PROCS (pps_pkg::MaxProcsDefault)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .in_kind_i          (in_kind_i),
    .in_proc_id_i       (in_proc_id_i),
    .in_arrival_i       (in_arrival_i),
    .in_burst_i         (in_burst_i),
    .in_prio_i          (in_prio_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_tick_time_i    (out_tick_time_o),
    .out_running_id_i   (out_running_id_o),
    .out_finish_valid_i (out_finish_valid_o),
    .out_finish_id_i    (out_finish_id_o),
    .out_turnaround_i   (out_turnaround_o),
    .out_waiting_i      (out_waiting_o),
    .out_response_i     (out_response_o),
    .out_all_done_i     (out_all_done_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_stall_i <= 1'b1;
      hold_served <= hold_asked;
      hold_left   <= LongHold;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: too long without any item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("preemptive_priority_scheduler_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, with random gaps first, and hold it until accepted
  task automatic put_item(pps_pkg::kind_e k, id_t id, tval_t arr, tval_t bur, prio_t pr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_kind_i    <= k;
    in_proc_id_i <= id;
    in_arrival_i <= arr;
    in_burst_i   <= bur;
    in_prio_i    <= pr;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (k != pps_pkg::KIND_NONE) items_sent++;
    if (k == pps_pkg::KIND_TICK) ticks_sent++;
  endtask

  // offer an item of the given kind with junk in the load fields
  task automatic put_junk(pps_pkg::kind_e k);
    put_item(k, id_t'($urandom), tval_t'($urandom), tval_t'($urandom), prio_t'($urandom));
  endtask

  // tick and clear carry junk in the load fields, which must be ignored
  task automatic send_tick();
    put_junk(pps_pkg::KIND_TICK);
  endtask

  task automatic send_clear();
    put_junk(pps_pkg::KIND_CLEAR);
  endtask

  task automatic send_unused();
    put_junk(pps_pkg::KIND_NONE);
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned n_loads;
    int unsigned prio_top;
    int unsigned tick_total;
    int unsigned latest;
    int unsigned arr;
    int unsigned bur;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, no idling ----
    send_tick();                                      // empty table: idle, all done
    send_unused();                                    // unused kind, no result
    put_item(pps_pkg::KIND_LOAD, 8'h00, 16'd0, 16'd5, 8'd0);   // zero id dropped
    put_item(pps_pkg::KIND_LOAD, 8'h05, 16'd0, 16'd0, 8'd0);   // zero burst dropped
    put_item(pps_pkg::KIND_LOAD, 8'hFF, 16'd0, 16'd2, 8'hFF);  // lowest priority
    put_item(pps_pkg::KIND_LOAD, 8'h01, 16'd1, 16'd1, 8'h00);  // highest priority, runs first at time 1
    // tie on priority, later arrival
    put_item(pps_pkg::KIND_LOAD, 8'h80, 16'd1, 16'd1, 8'hFF);
    // never arrives
    put_item(pps_pkg::KIND_LOAD, 8'h7F, 16'hFFFF, 16'hFFFF, 8'h80);
    repeat (4) send_tick();                           // last one runs the tie loser, not all done
    // loaded after ticks, already due
    put_item(pps_pkg::KIND_LOAD, 8'h42, 16'd2, 16'd2, 8'd7);
    repeat (2) send_tick();
    send_clear();
    send_tick();                                      // time back at zero
    drain_results();

    // ---- random schedules ----
    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      // rotate the idling mix so gaps land on every phase of a tick
      case (scenarios % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 67; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 67; end
        default: begin idle_pct = 35; stall_pct <= 35; end
      endcase
      send_clear();
      // now and then more loads than the table holds
      n_loads  = (scenarios == 0 || $urandom_range(7) == 0)
               ? pps_pkg::MaxProcsDefault + 2 : $urandom_range(1, 10);
      // narrow priority range to force ties
      prio_top = $urandom_range(1) ? 3 : 255;
      tick_total = 3;
      latest     = 0;
      repeat (n_loads) begin
        arr = $urandom_range(12);
        bur = $urandom_range(1, 5);
        case ($urandom_range(19))
          0: put_item(pps_pkg::KIND_LOAD, 8'h00, tval_t'(arr), tval_t'(bur),
                      prio_t'($urandom));
          1: put_item(pps_pkg::KIND_LOAD, id_t'($urandom_range(1, 255)), tval_t'(arr),
                      16'd0, prio_t'($urandom));
          2: put_junk(pps_pkg::KIND_LOAD);
          3: send_unused();
          default: begin
            put_item(pps_pkg::KIND_LOAD, id_t'($urandom_range(1, 255)), tval_t'(arr),
                     tval_t'(bur), prio_t'($urandom_range(prio_top)));
            tick_total += bur;
            if (arr > latest) latest = arr;
          end
        endcase
      end
      tick_total += latest;
      // first schedule: receiver holds off while ticks keep coming, so the
      // output register fills and the input stalls
      if (scenarios == 0) hold_asked <= hold_asked + 1;
      repeat (tick_total) begin
        case ($urandom_range(24))
          0: put_item(pps_pkg::KIND_LOAD, id_t'($urandom_range(1, 255)),
                      tval_t'($urandom_range(12)), tval_t'($urandom_range(1, 5)),
                      prio_t'($urandom_range(prio_top)));
          1: send_unused();
          default: ;
        endcase
        send_tick();
      end
      scenarios++;
      if (scenarios % 4 == 0) drain_results();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d items, %0d of them ticks: directed cases and",
             items_sent, ticks_sent);
    $display("%0d random schedules under four idling mixes", scenarios);
    if (fail_count == 0) begin
      $display("preemptive_priority_scheduler_top regression: pass");
    end else begin
      $display("preemptive_priority_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_slot_mem.sv
rtl/core/preemptive_priority_scheduler_top.sv
test/preemptive_priority_scheduler_checker.sv
test/tb_preemptive_priority_scheduler_top.sv
